// ===== design/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg: shared types and constants for the meter autorange controller
// register indexes, reset values and the classification word
// ----------------------------------------------------------------------------
package mac_pkg;

	localparam int SampleWidth = 16;
	localparam int RangeWidth  = 2;
	localparam int CfgIdxWidth = 3;

	typedef logic [SampleWidth-1:0] sample_t;
	typedef logic [RangeWidth-1:0]  range_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_LOW_WINDOW_FLOOR   = 3'd0,
		CFG_LOW_WINDOW_CEILING = 3'd1,
		CFG_OVER_LIMIT_LOW     = 3'd2,
		CFG_OVER_LIMIT_HIGH    = 3'd3
	} cfg_index_t;

	localparam sample_t LowFloorReset   = 16'd0;
	localparam sample_t LowCeilReset    = 16'd6553;
	localparam sample_t OverLowReset    = 16'd0;
	localparam sample_t OverHighReset   = 16'd62258;

	localparam range_t RangeMin = 2'd0;
	localparam range_t RangeMax = 2'd2;

	// sample class against the threshold window
	typedef struct packed {
		logic low;
		logic high;
	} mac_class_t;

	// thresholds as one bundle
	typedef struct packed {
		sample_t low_floor;
		sample_t low_ceil;
		sample_t over_low;
		sample_t over_high;
	} mac_thresh_t;

	// range state and the switch flag of one step
	typedef struct packed {
		range_t range;
		logic   extra;
		logic   pin;
		logic   switched;
	} mac_state_t;

endpackage

// ===== design/mac_classify.sv =====
// ----------------------------------------------------------------------------
// mac_classify: threshold compare for one sample
// flags a reading as low (inside the window) and high (outside the limits)
// ----------------------------------------------------------------------------
module mac_classify (
	input  mac_pkg::sample_t    sample,
	input  mac_pkg::mac_thresh_t thresh,
	output mac_pkg::mac_class_t cls
);
	import mac_pkg::*;

	always_comb begin
		cls.low  = (sample > thresh.low_floor) && (sample < thresh.low_ceil);
		cls.high = (sample > thresh.over_high) || (sample < thresh.over_low);
	end

endmodule

// ===== design/mac_range_step.sv =====
// ----------------------------------------------------------------------------
// mac_range_step: range state registers and next-state logic
// one step per registered word, new state visible to the next word at once
// ----------------------------------------------------------------------------
module mac_range_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  mac_pkg::mac_class_t cls,
	input  logic                res_mode,
	output mac_pkg::mac_state_t nxt
);
	import mac_pkg::*;

	range_t range_q;
	logic   extra_q;
	logic   pin_q;

	always_comb begin
		range_t r;
		logic   ex;
		logic   sw;
		r  = range_q;
		ex = extra_q;
		sw = 1'b0;
		if (!res_mode) begin
			ex = 1'b0;
			if (cls.high && r != RangeMin) begin
				r  = r - 2'd1;
				sw = 1'b1;
			end else if (cls.low && r != RangeMax) begin
				r  = r + 2'd1;
				sw = 1'b1;
			end
		end else if (!extra_q) begin
			// low reading at top range wraps into extra gain
			if (cls.low && r == RangeMax) begin
				r  = RangeMin;
				ex = 1'b1;
				sw = 1'b1;
			end else if (cls.low) begin
				r  = r + 2'd1;
				sw = 1'b1;
			end
			if (cls.high && r != RangeMin) begin
				r  = r - 2'd1;
				sw = 1'b1;
			end
		end else begin
			if (cls.low && r != RangeMax) begin
				r  = r + 2'd1;
				sw = 1'b1;
			end
			// high reading at bottom range leaves extra gain
			if (cls.high && r != RangeMin) begin
				r  = r - 2'd1;
				sw = 1'b1;
			end else if (cls.high) begin
				r  = RangeMax;
				ex = 1'b0;
				sw = 1'b1;
			end
		end
		nxt.range    = r;
		nxt.extra    = ex;
		nxt.switched = sw;
		nxt.pin      = (sw && r == RangeMin) ? ex : pin_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RangeMin;
			extra_q <= 1'b0;
			pin_q   <= 1'b0;
		end else if (step_en) begin
			range_q <= nxt.range;
			extra_q <= nxt.extra;
			pin_q   <= nxt.pin;
		end
	end

endmodule

// ===== design/meter_autorange_controller.sv =====
// ----------------------------------------------------------------------------
// meter_autorange_controller: gain autoranging for a meter front end
// classifies each sample against programmable limits and steps the range
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | sample, resistance_mode
//  out      | out_valid / out_ready| range_now, mux_pins, resistance_gain_pin,
//           |                      | extra_gain, range_switched
//  cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word per cycle sustained while the output is not stalled; a word passes through the
// input register with compare flags, then the range step into the output register
// range state updates as a word moves into the output register, so the next word
// already sees it; an output stall holds the output word and backs up into in_ready
// reset clears range, extra flag and pin to zero and loads threshold defaults
// cfg writes are always taken; index above three is ignored
// ----------------------------------------------------------------------------
module meter_autorange_controller (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mac_pkg::sample_t    sample,
	input  logic                resistance_mode,
	output logic                out_valid,
	input  logic                out_ready,
	output mac_pkg::range_t     range_now,
	output mac_pkg::range_t     mux_pins,
	output logic                resistance_gain_pin,
	output logic                extra_gain,
	output logic                range_switched,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [mac_pkg::CfgIdxWidth-1:0] cfg_index,
	input  mac_pkg::sample_t    cfg_data
);
	import mac_pkg::*;

	// threshold registers
	mac_thresh_t thresh_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q.low_floor <= LowFloorReset;
			thresh_q.low_ceil  <= LowCeilReset;
			thresh_q.over_low  <= OverLowReset;
			thresh_q.over_high <= OverHighReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOW_WINDOW_FLOOR:   thresh_q.low_floor <= cfg_data;
				CFG_LOW_WINDOW_CEILING: thresh_q.low_ceil  <= cfg_data;
				CFG_OVER_LIMIT_LOW:     thresh_q.over_low  <= cfg_data;
				CFG_OVER_LIMIT_HIGH:    thresh_q.over_high <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: compare flags and mode, registered
	mac_class_t cls_in;
	mac_class_t cls_s1;
	logic       res_s1;
	logic       valid_s1;
	logic       load_out;
	logic       accept_in;

	mac_classify u_classify (
		.sample (sample),
		.thresh (thresh_q),
		.cls    (cls_in)
	);

	// output slot free or draining this cycle
	assign load_out  = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || load_out;
	assign accept_in = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			cls_s1 <= cls_in;
			res_s1 <= resistance_mode;
		end
	end

	// stage 2: range step and output register
	mac_state_t nxt;

	mac_range_step u_range_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (load_out),
		.cls      (cls_s1),
		.res_mode (res_s1),
		.nxt      (nxt)
	);

	mac_state_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= nxt;
		end
	end

	assign range_now           = out_q.range;
	assign mux_pins            = out_q.range;
	assign resistance_gain_pin = out_q.pin;
	assign extra_gain          = out_q.extra;
	assign range_switched      = out_q.switched;

	// range never reaches code three
	a_range_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (range_now != 2'd3))
		else $error("range code three on output");

	// a stalled output with a word waiting blocks the input
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && valid_s1) |-> !in_ready)
		else $error("input taken while stage full and output stalled");

	// the pin only moves on a switch to range zero
	a_pin_on_switch: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && !nxt.switched) |=> (resistance_gain_pin == $past(u_range_step.pin_q)))
		else $error("pin changed without a switch");

	// output word holds while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_q)))
		else $error("output word changed under stall");

endmodule
